// File: rtl/sle_pkg.sv
// Shared types, character constants and decode helpers for the string literal unescaper.
`default_nettype none

package sle_pkg;

  localparam int unsigned CodeW      = 21;
  localparam int unsigned CharW      = 8;
  localparam int unsigned AccW       = 12;
  localparam int unsigned CharLimit  = 256;
  localparam int unsigned MaxResults = 2;
  localparam int unsigned OutDepth   = 4;
  localparam int unsigned OutPtrW    = $clog2(OutDepth);
  localparam int unsigned OutCntW    = $clog2(OutDepth + 1);
  localparam int unsigned InDataW    = 24;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutDataW   = 8;
  localparam int unsigned OutUserW   = 2;

  localparam logic [CodeW-1:0] ChQuote  = CodeW'(8'h22);
  localparam logic [CodeW-1:0] ChApos   = CodeW'(8'h27);
  localparam logic [CodeW-1:0] ChBslash = CodeW'(8'h5c);
  localparam logic [CodeW-1:0] Ch0      = CodeW'(8'h30);
  localparam logic [CodeW-1:0] Ch7      = CodeW'(8'h37);
  localparam logic [CodeW-1:0] Ch9      = CodeW'(8'h39);
  localparam logic [CodeW-1:0] ChLa     = CodeW'(8'h61);
  localparam logic [CodeW-1:0] ChLb     = CodeW'(8'h62);
  localparam logic [CodeW-1:0] ChLf     = CodeW'(8'h66);
  localparam logic [CodeW-1:0] ChLn     = CodeW'(8'h6e);
  localparam logic [CodeW-1:0] ChLo     = CodeW'(8'h6f);
  localparam logic [CodeW-1:0] ChLr     = CodeW'(8'h72);
  localparam logic [CodeW-1:0] ChLt     = CodeW'(8'h74);
  localparam logic [CodeW-1:0] ChLv     = CodeW'(8'h76);
  localparam logic [CodeW-1:0] ChLx     = CodeW'(8'h78);
  localparam logic [CodeW-1:0] ChUa     = CodeW'(8'h41);
  localparam logic [CodeW-1:0] ChUf     = CodeW'(8'h46);
  localparam logic [CodeW-1:0] LowerHexBase = ChLa - CodeW'(10);
  localparam logic [CodeW-1:0] UpperHexBase = ChUa - CodeW'(10);

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_TEXT = 6'b000010,
    PH_ESC  = 6'b000100,
    PH_DEC  = 6'b001000,
    PH_OCT  = 6'b010000,
    PH_HEX  = 6'b100000
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] ch;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic             has;
    kind_e            kind;
    logic [CharW-1:0] ch;
    phase_e           phase;
    logic             clr;
  } content_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic content_t content_step(logic eot, logic [CodeW-1:0] c);
    content_t r;
    r.has   = 1'b1;
    r.kind  = KIND_FAIL;
    r.ch    = '0;
    r.phase = PH_IDLE;
    r.clr   = 1'b1;
    if (!eot) begin
      if (c == ChQuote) begin
        r.kind = KIND_CLOSE;
      end else if (c == ChBslash) begin
        r.has   = 1'b0;
        r.phase = PH_ESC;
        r.clr   = 1'b0;
      end else if (c < CodeW'(CharLimit)) begin
        r.kind  = KIND_CHAR;
        r.ch    = c[CharW-1:0];
        r.phase = PH_TEXT;
        r.clr   = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic digit_t digit_of(logic [CodeW-1:0] c, phase_e ph);
    digit_t d;
    d.ok  = 1'b0;
    d.val = '0;
    if (c >= Ch0 && c <= Ch9) begin
      d.val = 4'(c - Ch0);
      d.ok  = (ph == PH_DEC) || (ph == PH_HEX) || (c <= Ch7);
    end else if (ph == PH_HEX && c >= ChLa && c <= ChLf) begin
      d.val = 4'(c - LowerHexBase);
      d.ok  = 1'b1;
    end else if (ph == PH_HEX && c >= ChUa && c <= ChUf) begin
      d.val = 4'(c - UpperHexBase);
      d.ok  = 1'b1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sle_core.sv
// Input register, literal state and single-pass escape decode.
`default_nettype none

module sle_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sle_pkg::InDataW-1:0] s_axis_tdata,
  input  logic [sle_pkg::InUserW-1:0] s_axis_tuser,
  input  logic                        room_i,
  output sle_pkg::push_t              push_o
);
  import sle_pkg::*;

  logic             in_valid_q;
  logic             in_start_q;
  logic             in_eot_q;
  logic [CodeW-1:0] in_code_q;
  phase_e           phase_q, phase_d;
  logic [AccW-1:0]  accum_q, accum_d;
  logic             advance;
  logic             load;
  content_t         cs;
  digit_t           dg;
  logic [AccW-1:0]  acc_next;
  logic [1:0]       n;
  result_t          r0, r1;

  assign advance       = in_valid_q & room_i;
  assign s_axis_tready = ~in_valid_q | room_i;
  assign load          = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_start_q <= s_axis_tuser[0];
      in_eot_q   <= s_axis_tuser[1];
      in_code_q  <= s_axis_tdata[CodeW-1:0];
    end
  end

  always_comb begin
    dg = digit_of(in_code_q, phase_q);
    unique case (phase_q)
      PH_DEC:  acc_next = {accum_q[AccW-4:0], 3'b000} + {accum_q[AccW-2:0], 1'b0}
                          + AccW'(dg.val);
      PH_OCT:  acc_next = {accum_q[AccW-4:0], 3'b000} + AccW'(dg.val);
      default: acc_next = {accum_q[AccW-5:0], 4'b0000} + AccW'(dg.val);
    endcase
  end

  always_comb begin
    cs      = content_step(in_eot_q, in_code_q);
    phase_d = phase_q;
    accum_d = accum_q;
    n       = 2'd0;
    r0      = '{kind: KIND_FAIL, ch: '0, last: 1'b1};
    r1      = '{kind: KIND_FAIL, ch: '0, last: 1'b1};
    if (in_start_q) begin
      accum_d = '0;
      if (!in_eot_q && in_code_q == ChQuote) begin
        phase_d = PH_TEXT;
      end else begin
        phase_d = PH_IDLE;
        n       = 2'd1;
      end
    end else begin
      unique case (phase_q)
        PH_TEXT: begin
          phase_d = cs.phase;
          if (cs.clr) accum_d = '0;
          if (cs.has) begin
            n  = 2'd1;
            r0 = '{kind: cs.kind, ch: cs.ch, last: 1'b1};
          end
        end
        PH_ESC: begin
          phase_d = PH_TEXT;
          n       = 2'd1;
          r0.kind = KIND_CHAR;
          if (in_eot_q) begin
            phase_d = PH_IDLE;
            accum_d = '0;
            r0.kind = KIND_FAIL;
          end else begin
            case (in_code_q)
              ChBslash, ChQuote, ChApos: r0.ch = in_code_q[CharW-1:0];
              ChLa: r0.ch = CharW'(7);
              ChLb: r0.ch = CharW'(8);
              ChLf: r0.ch = CharW'(12);
              ChLn: r0.ch = CharW'(10);
              ChLr: r0.ch = CharW'(13);
              ChLt: r0.ch = CharW'(9);
              ChLv: r0.ch = CharW'(11);
              ChLo: begin
                n       = 2'd0;
                accum_d = '0;
                phase_d = PH_OCT;
              end
              ChLx: begin
                n       = 2'd0;
                accum_d = '0;
                phase_d = PH_HEX;
              end
              default: begin
                if (in_code_q >= Ch0 && in_code_q <= Ch9) begin
                  n       = 2'd0;
                  accum_d = AccW'(in_code_q - Ch0);
                  phase_d = PH_DEC;
                end else begin
                  phase_d = PH_IDLE;
                  accum_d = '0;
                  r0.kind = KIND_FAIL;
                end
              end
            endcase
          end
        end
        PH_DEC, PH_OCT, PH_HEX: begin
          if (!in_eot_q && dg.ok) begin
            if (accum_q < AccW'(CharLimit)) accum_d = acc_next;
          end else if (accum_q >= AccW'(CharLimit)) begin
            n       = 2'd1;
            phase_d = PH_IDLE;
            accum_d = '0;
          end else begin
            accum_d = '0;
            phase_d = cs.phase;
            r0      = '{kind: KIND_CHAR, ch: accum_q[CharW-1:0], last: ~cs.has};
            r1      = '{kind: cs.kind, ch: cs.ch, last: 1'b1};
            n       = cs.has ? 2'd2 : 2'd1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          accum_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      accum_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
    end
  end

  assign push_o.n  = advance ? n : 2'd0;
  assign push_o.r0 = r0;
  assign push_o.r1 = r1;

endmodule

`default_nettype wire

// File: rtl/sle_out_fifo.sv
// Result queue: up to two results in a cycle, one word out a cycle on tready.
`default_nettype none

module sle_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sle_pkg::push_t               push_i,
  output logic                         room_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sle_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [sle_pkg::OutUserW-1:0] m_axis_tuser,
  output logic                         m_axis_tlast
);
  import sle_pkg::*;

  result_t            mem_q [OutDepth];
  logic [OutPtrW-1:0] wptr_q, rptr_q;
  logic [OutCntW-1:0] cnt_q;
  logic               pop;
  result_t            head;

  assign pop    = m_axis_tvalid & m_axis_tready;
  assign room_o = cnt_q <= OutCntW'(OutDepth - MaxResults);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wptr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wptr_q + OutPtrW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + OutPtrW'(push_i.n);
      rptr_q <= rptr_q + OutPtrW'(pop);
      cnt_q  <= cnt_q + OutCntW'(push_i.n) - OutCntW'(pop);
    end
  end

  assign head          = mem_q[rptr_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = head.ch;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

endmodule

`default_nettype wire

// File: rtl/string_literal_unescaper.sv
// Top level of the double-quoted string literal unescaper.
//
//  channel   dir  tdata               tuser                          tlast
//  s_axis    in   [20:0] code         [0] start_req [1] end_of_text  -
//  m_axis    out  [7:0] out_char      [1:0] kind                     last
//
// One word in per cycle; a word is decoded in one pass between the input
// register and the result queue; its results enter the queue as the word leaves
// the register. Input stalls while a word is held and three or more results wait
// in the four-entry queue; under a stalled output the queue drain sets the rate.
// Reset idles the decoder and empties the queue; no clearing pass.
`default_nettype none

module string_literal_unescaper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [sle_pkg::InDataW-1:0]  s_axis_tdata,  // [20:0] code, [23:21] zero
  input  logic [sle_pkg::InUserW-1:0]  s_axis_tuser,  // [0] start_req, [1] end_of_text
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sle_pkg::OutDataW-1:0] m_axis_tdata,  // [7:0] out_char
  output logic [sle_pkg::OutUserW-1:0] m_axis_tuser,  // [1:0] kind
  output logic                         m_axis_tlast
);
  import sle_pkg::*;

  push_t push;
  logic  room;

  sle_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .room_i        (room),
    .push_o        (push)
  );

  sle_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/sle_checker.sv
// Port-level checks of the string literal unescaper, bound to the top level.
`default_nettype none

module sle_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [sle_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [sle_pkg::OutUserW-1:0] m_axis_tuser,
  input logic                         m_axis_tlast
);
  import sle_pkg::*;

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_CHAR || m_axis_tuser == KIND_CLOSE ||
                       m_axis_tuser == KIND_FAIL))
    else $error("result kind out of range");

  a_status_zero_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_CHAR) |-> m_axis_tdata == '0)
    else $error("status word carries a character");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_CHAR) |-> m_axis_tlast)
    else $error("status word not marked last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule

bind string_literal_unescaper sle_checker u_sle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/sv/string_literal_unescaper_tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the string literal unescaper with its own decoder model.
module string_literal_unescaper_tb;
  import sle_pkg::*;

  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned WordsPerPass = 155;

  localparam logic [CodeW-1:0] CodeMax    = CodeW'(1114111);
  localparam logic [CodeW-1:0] UnknownEsc = CodeW'(8'h71);

  localparam logic [CharW-1:0] CtlBel = 8'd7;
  localparam logic [CharW-1:0] CtlBs  = 8'd8;
  localparam logic [CharW-1:0] CtlHt  = 8'd9;
  localparam logic [CharW-1:0] CtlLf  = 8'd10;
  localparam logic [CharW-1:0] CtlVt  = 8'd11;
  localparam logic [CharW-1:0] CtlFf  = 8'd12;
  localparam logic [CharW-1:0] CtlCr  = 8'd13;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] ch;
    logic             last;
  } decoded_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // [20:0] code, [23:21] zero
  logic [InUserW-1:0]  s_axis_tuser  = '0;  // [0] start_req, [1] end_of_text
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [7:0] out_char
  logic [OutUserW-1:0] m_axis_tuser;        // [1:0] kind
  logic                m_axis_tlast;

  phase_e           lit_phase = PH_IDLE;
  logic [AccW-1:0]  lit_acc   = '0;
  decoded_t         word_results[$];
  decoded_t         expected_q[$];

  int errors          = 0;
  int words_sent      = 0;
  int words_decoded   = 0;
  int results_checked = 0;
  int closes_seen     = 0;
  int fails_seen      = 0;
  int send_idle_pct   = 16;
  int recv_idle_pct   = 76;
  int quiet_cycles    = 0;

  string_literal_unescaper u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- decoder model

  function automatic void emit_result(kind_e k, logic [CharW-1:0] ch);
    decoded_t r;
    r.kind = k;
    r.ch   = (k == KIND_CHAR) ? ch : '0;
    r.last = 1'b0;
    word_results.push_back(r);
  endfunction

  function automatic void abort_literal();
    emit_result(KIND_FAIL, '0);
    lit_phase = PH_IDLE;
    lit_acc   = '0;
  endfunction

  function automatic void take_content(logic eot, logic [CodeW-1:0] c);
    if (eot) begin
      abort_literal();
    end else if (c == ChQuote) begin
      emit_result(KIND_CLOSE, '0);
      lit_phase = PH_IDLE;
      lit_acc   = '0;
    end else if (c == ChBslash) begin
      lit_phase = PH_ESC;
    end else if (c < CodeW'(CharLimit)) begin
      emit_result(KIND_CHAR, c[CharW-1:0]);
    end else begin
      abort_literal();
    end
  endfunction

  function automatic void take_digit(int radix, logic eot, logic [CodeW-1:0] c);
    int d;
    d = -1;
    if (!eot) begin
      if (c >= Ch0 && c <= Ch9 && int'(c - Ch0) < radix) begin
        d = int'(c - Ch0);
      end else if (radix == 16 && c >= ChLa && c <= ChLf) begin
        d = int'(c - ChLa) + 10;
      end else if (radix == 16 && c >= ChUa && c <= ChUf) begin
        d = int'(c - ChUa) + 10;
      end
    end
    if (d >= 0) begin
      if (lit_acc < AccW'(CharLimit)) lit_acc = AccW'(radix * int'(lit_acc) + d);
    end else if (lit_acc >= AccW'(CharLimit)) begin
      abort_literal();
    end else begin
      emit_result(KIND_CHAR, lit_acc[CharW-1:0]);
      lit_acc   = '0;
      lit_phase = PH_TEXT;
      take_content(eot, c);
    end
  endfunction

  // Returns 1 when the word falls outside any literal and is dropped.
  function automatic bit decode_word(logic start, logic eot, logic [CodeW-1:0] c);
    bit               dropped;
    bit               esc_ok;
    logic [CharW-1:0] esc_ch;
    decoded_t         r;
    dropped = 1'b0;
    esc_ok  = 1'b0;
    esc_ch  = '0;
    word_results.delete();
    if (start) begin
      lit_acc = '0;
      if (!eot && c == ChQuote) lit_phase = PH_TEXT;
      else abort_literal();
    end else begin
      case (lit_phase)
        PH_TEXT: take_content(eot, c);
        PH_ESC: begin
          if (eot) begin
            abort_literal();
          end else begin
            esc_ok = 1'b1;
            case (c)
              ChBslash, ChQuote, ChApos: esc_ch = c[CharW-1:0];
              ChLa: esc_ch = CtlBel;
              ChLb: esc_ch = CtlBs;
              ChLf: esc_ch = CtlFf;
              ChLn: esc_ch = CtlLf;
              ChLr: esc_ch = CtlCr;
              ChLt: esc_ch = CtlHt;
              ChLv: esc_ch = CtlVt;
              ChLo, ChLx: begin
                esc_ok    = 1'b0;
                lit_acc   = '0;
                lit_phase = (c == ChLo) ? PH_OCT : PH_HEX;
              end
              default: begin
                esc_ok = 1'b0;
                if (c >= Ch0 && c <= Ch9) begin
                  lit_acc   = AccW'(c - Ch0);
                  lit_phase = PH_DEC;
                end else begin
                  abort_literal();
                end
              end
            endcase
            if (esc_ok) begin
              emit_result(KIND_CHAR, esc_ch);
              lit_phase = PH_TEXT;
            end
          end
        end
        PH_DEC: take_digit(10, eot, c);
        PH_OCT: take_digit(8, eot, c);
        PH_HEX: take_digit(16, eot, c);
        default: begin
          dropped   = 1'b1;
          lit_phase = PH_IDLE;
          lit_acc   = '0;
        end
      endcase
    end
    if (word_results.size() > 0) begin
      r = word_results.pop_back();
      r.last = 1'b1;
      word_results.push_back(r);
    end
    foreach (word_results[i]) expected_q.push_back(word_results[i]);
    return dropped;
  endfunction

  // ---------------------------------------------------------------- drivers

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(input logic start, input logic eot, input logic [CodeW-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(code);
    s_axis_tuser  <= {eot, start};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    if (!decode_word(start, eot, code)) words_decoded++;
  endtask

  task automatic send_char(input logic [CodeW-1:0] code);
    send_word(1'b0, 1'b0, code);
  endtask

  task automatic send_open();
    send_word(1'b1, 1'b0, ChQuote);
  endtask

  function automatic logic [CodeW-1:0] any_code();
    return CodeW'($urandom_range(CodeMax));
  endfunction

  function automatic logic [CodeW-1:0] simple_escape();
    case ($urandom_range(9))
      0: return ChBslash;
      1: return ChQuote;
      2: return ChApos;
      3: return ChLa;
      4: return ChLb;
      5: return ChLf;
      6: return ChLn;
      7: return ChLr;
      8: return ChLt;
      default: return ChLv;
    endcase
  endfunction

  function automatic logic [CodeW-1:0] hex_digit();
    int v;
    v = $urandom_range(15);
    if (v < 10) return CodeW'(Ch0 + v);
    if ($urandom_range(1)) return CodeW'(ChUa + v - 10);
    return CodeW'(ChLa + v - 10);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_openings();
    send_char(CodeMax);
    send_word(1'b1, 1'b0, ChLa);
    send_word(1'b1, 1'b1, ChQuote);
  endtask

  task automatic test_empty_code();
    send_open();
    send_char('0);
    send_char(ChBslash);
    send_char(ChLo);
    send_char(ChQuote);
  endtask

  task automatic test_restart_and_saturation();
    send_open();
    send_char(CodeW'(8'hff));
    send_open();
    send_char(ChBslash);
    send_char(ChLx);
    send_char(CodeW'(Ch0 + 1));
    send_char(Ch0);
    send_char(Ch0);
    send_char(ChUf);
    send_char(ChQuote);
  endtask

  task automatic test_early_end();
    send_open();
    send_char(ChBslash);
    send_char(Ch9);
    send_char(CodeW'(Ch0 + 8));
    send_word(1'b0, 1'b1, CodeMax);
  endtask

  task automatic test_octal_bound_and_wide();
    send_open();
    send_char(ChBslash);
    send_char(ChLo);
    send_char(Ch7);
    send_char(CodeW'(Ch0 + 8));
    send_char(CodeW'(CharLimit));
  endtask

  task automatic test_unknown_escape();
    send_open();
    send_char(ChBslash);
    send_char(UnknownEsc);
  endtask

  task automatic send_random_literal();
    int pick;
    if ($urandom_range(99) < 3) send_word(1'b1, 1'($urandom_range(1)), any_code());
    else send_open();
    repeat ($urandom_range(8)) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_char(CodeW'($urandom_range(255)));
      end else if (pick < 50) begin
        send_char(ChBslash);
        send_char(simple_escape());
      end else if (pick < 62) begin
        send_char(ChBslash);
        send_char(CodeW'(Ch0 + $urandom_range(9)));
        repeat ($urandom_range(3)) send_char(CodeW'(Ch0 + $urandom_range(9)));
      end else if (pick < 74) begin
        send_char(ChBslash);
        send_char(ChLo);
        repeat ($urandom_range(4)) send_char(CodeW'(Ch0 + $urandom_range(7)));
      end else if (pick < 86) begin
        send_char(ChBslash);
        send_char(ChLx);
        repeat ($urandom_range(3)) send_char(hex_digit());
      end else if (pick < 90) begin
        send_char(CodeW'($urandom_range(CodeMax, CharLimit)));
      end else if (pick < 93) begin
        send_char(ChBslash);
        send_char(any_code());
      end else if (pick < 96) begin
        send_word(1'b0, 1'b1, any_code());
      end else if (pick < 98) begin
        send_open();
      end else begin
        send_char(any_code());
      end
    end
    pick = $urandom_range(99);
    if (pick < 88) send_char(ChQuote);
    else if (pick < 95) send_word(1'b0, 1'b1, any_code());
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(3, 1)) send_word(1'b0, 1'($urandom_range(1)), any_code());
    end
  endtask

  task automatic test_random(input int send_pct, input int recv_pct);
    int goal;
    goal          = words_sent + WordsPerPass;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (words_sent < goal) send_random_literal();
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : check_results
    decoded_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d, out_char 0x%02h, last %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (want.kind == KIND_CLOSE) closes_seen++;
        if (want.kind == KIND_FAIL) fails_seen++;
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata !== want.ch) begin
          $error("out_char: expected 0x%02h, got 0x%02h", want.ch, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $error("no word moved for %0d cycles, %0d results still due",
             quiet_cycles, expected_q.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_openings();
    test_empty_code();
    test_restart_and_saturation();
    test_early_end();
    test_octal_bound_and_wide();
    test_unknown_escape();
    test_random(16, 76);
    test_random(76, 16);
    test_random(0, 0);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d words, %0d of them inside literals, checked %0d results",
             words_sent, words_decoded, results_checked);
    $display("literals closed: %0d, literals failed: %0d", closes_seen, fails_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sle_pkg.sv
rtl/sle_core.sv
rtl/sle_out_fifo.sv
rtl/string_literal_unescaper.sv
rtl/sle_checker.sv
tb/sv/string_literal_unescaper_tb.sv
